>>> hdl/lct_pkg.sv
// Shared types and constants for the LFU cache table.
// Used by lct_ctrl, lct_dp and lfu_cache_table_core. No dependencies.
package lct_pkg;

  localparam int KEY_W   = 17;
  localparam int VALUE_W = 30;
  localparam int CLOCK_W = 32;
  localparam int CAP_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes on the mode input
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic clr_wr;     // write an empty entry at the sweep counter
    logic scan_init;  // capture item, clear scan accumulators
    logic rd;         // read entry at the sweep counter
    logic finish;     // write back, update clock, load result
  } lct_cmd_t;

  typedef struct packed {
    logic cnt_last;   // sweep counter at the last entry
    logic out_free;   // result register can take a new result
  } lct_status_t;

endpackage

>>> hdl/lct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/lct_ctrl.sv
// Sequencer for the LFU cache table: clearing sweep, scan, write-back.
// Depends on lct_pkg for the command and status structs.
module lct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lct_pkg::lct_status_t status,
  output lct_pkg::lct_cmd_t    cmd
);
  import lct_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.cnt_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd = 1'b1;
        if (status.cnt_last) state_next = S_DRAIN;
      end
      // last read word is folded in here
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

>>> hdl/lct_dp.sv
// Datapath for the LFU cache table: entry RAM, scan accumulators, victim
// choice, write-back and result register. Depends on lct_pkg and lct_ram.
module lct_dp #(
  parameter int ENTRIES  = 16,
  parameter int USE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lct_pkg::lct_cmd_t             cmd,
  output lct_pkg::lct_status_t          status,
  input  logic [lct_pkg::CAP_W-1:0]     capacity,
  input  logic                          mode,
  input  logic [lct_pkg::KEY_W-1:0]     key,
  input  logic [lct_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [lct_pkg::VALUE_W-1:0]   read_value,
  output logic                          evicted,
  output logic [lct_pkg::KEY_W-1:0]     evicted_key
);
  import lct_pkg::*;

  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int LU_LSB   = 0;
  localparam int USES_LSB = CLOCK_W;
  localparam int VAL_LSB  = USES_LSB + USE_BITS;
  localparam int KEY_LSB  = VAL_LSB + VALUE_W;
  localparam int VLD_BIT  = KEY_LSB + KEY_W;
  localparam int WORD_W   = VLD_BIT + 1;

  logic [IDX_W-1:0]   cnt;
  logic               rd_q;
  logic [IDX_W-1:0]   proc_idx;
  logic [WORD_W-1:0]  rdata;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  logic               mode_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;
  logic [CLOCK_W-1:0] use_clock;

  logic [CNT_W-1:0]    valid_cnt;
  logic                found;
  logic [IDX_W-1:0]    found_idx;
  logic [VALUE_W-1:0]  found_value;
  logic [USE_BITS-1:0] found_uses;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic                vic_found;
  logic [IDX_W-1:0]    vic_idx;
  logic [KEY_W-1:0]    vic_key;
  logic [USE_BITS-1:0] vic_uses;
  logic [CLOCK_W-1:0]  vic_age;

  logic                w_valid;
  logic [KEY_W-1:0]    w_key;
  logic [VALUE_W-1:0]  w_value;
  logic [USE_BITS-1:0] w_uses;
  logic [CLOCK_W-1:0]  w_last;
  logic [CLOCK_W-1:0]  w_age;
  logic                w_better;

  logic [CMP_W-1:0]    cap_eff;
  logic                cap_zero;
  logic                full;
  logic                do_write;
  logic                do_evict;
  logic [IDX_W-1:0]    wr_idx;
  logic [USE_BITS-1:0] wr_uses;
  logic [VALUE_W-1:0]  wr_value;

  lct_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (cnt),
    .rdata (rdata)
  );

  assign w_valid = rdata[VLD_BIT];
  assign w_key   = rdata[KEY_LSB +: KEY_W];
  assign w_value = rdata[VAL_LSB +: VALUE_W];
  assign w_uses  = rdata[USES_LSB +: USE_BITS];
  assign w_last  = rdata[LU_LSB +: CLOCK_W];
  // modular age: larger means used longer ago
  assign w_age   = use_clock - w_last;
  assign w_better = !vic_found || (w_uses < vic_uses) ||
                    ((w_uses == vic_uses) && (w_age > vic_age));

  assign status.cnt_last = (cnt == IDX_W'(ENTRIES - 1));
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    cap_eff  = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
    cap_zero = (capacity == '0);
    full     = (CMP_W'(valid_cnt) >= cap_eff);
    if (found) begin
      do_write = (mode_q == MODE_GET) || !cap_zero;
    end else begin
      do_write = (mode_q == MODE_PUT) && !cap_zero;
    end
    do_evict = (mode_q == MODE_PUT) && !cap_zero && !found && full;
    priority if (found) wr_idx = found_idx;
    else if (full)      wr_idx = vic_idx;
    else                wr_idx = free_idx;
    if (!found) begin
      wr_uses = USE_BITS'(1);
    end else if (found_uses == '1) begin
      wr_uses = found_uses;
    end else begin
      wr_uses = found_uses + USE_BITS'(1);
    end
    wr_value = (mode_q == MODE_PUT) ? value_q : found_value;

    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.finish && do_write) begin
      ram_we    = 1'b1;
      ram_waddr = wr_idx;
      ram_wdata = {1'b1, key_q, wr_value, wr_uses, use_clock};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_q      <= 1'b0;
      use_clock <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_q <= cmd.rd;
      if (cmd.scan_init) begin
        cnt <= '0;
      end else if (cmd.clr_wr || cmd.rd) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (cmd.finish && do_write) begin
        use_clock <= use_clock + CLOCK_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan accumulators, one entry per cycle
  always_ff @(posedge clk) begin
    proc_idx <= cnt;
    if (cmd.scan_init) begin
      mode_q     <= mode;
      key_q      <= key;
      value_q    <= value;
      valid_cnt  <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      vic_found  <= 1'b0;
    end else if (rd_q) begin
      if (w_valid) begin
        valid_cnt <= valid_cnt + CNT_W'(1);
        if (!found && (w_key == key_q)) begin
          found       <= 1'b1;
          found_idx   <= proc_idx;
          found_value <= w_value;
          found_uses  <= w_uses;
        end
        if (w_better) begin
          vic_found <= 1'b1;
          vic_idx   <= proc_idx;
          vic_key   <= w_key;
          vic_uses  <= w_uses;
          vic_age   <= w_age;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= proc_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hit         <= found;
      read_value  <= (found && (mode_q == MODE_GET)) ? found_value : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? vic_key : '0;
    end
  end

endmodule

>>> hdl/lfu_cache_table_core.sv
// Top level of the LFU cache table: APB capacity register, sequencer and
// datapath. Depends on lct_pkg, lct_ctrl and lct_dp (which holds lct_ram).
//
//   port group   handshake                    carries
//   in           in_valid / in_ready          mode, key, value
//   out          out_valid / out_ready        hit, read_value, evicted, evicted_key
//   apb          psel, penable, pready        capacity_in_use at paddr 0
//
// An item passes the accept state, one entry RAM read per cycle over all
// slots (match, free slot, victim), a drain state for the last read word and
// the write-back. The write-back waits while the result register is full
// and not taken. After reset a clearing sweep over all ENTRIES slots empties
// the table; no item is taken during it, APB writes are.
module lfu_cache_table_core #(
  parameter int ENTRIES  = 16,
  parameter int USE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [lct_pkg::KEY_W-1:0]     key,
  input  logic [lct_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [lct_pkg::VALUE_W-1:0]   read_value,
  output logic                          evicted,
  output logic [lct_pkg::KEY_W-1:0]     evicted_key,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lct_pkg::PADDR_W-1:0]   paddr,
  input  logic [lct_pkg::PDATA_W-1:0]   pwdata,
  output logic [lct_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import lct_pkg::*;

  logic [CAP_W-1:0] capacity_in_use;
  lct_cmd_t         cmd;
  lct_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity_in_use <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_in_use) : '0;

  lct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lct_dp #(
    .ENTRIES  (ENTRIES),
    .USE_BITS (USE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .capacity    (capacity_in_use),
    .mode        (mode),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

endmodule
